// ===== sv/bui_pkg.sv =====
`default_nettype none

package bui_pkg;

    // sizing
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_SCALE = 16;

    // field widths
    localparam int CMD_W   = 1;
    localparam int PIX_W   = 24;
    localparam int SCALE_W = 5;
    localparam int WIDTH_W = 11;
    localparam int PAD_W   = 2;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROWS_W  = $clog2(MAX_SCALE);
    localparam int CNT_W   = $clog2(MAX_SCALE + 1);

    // config port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    // input commands
    localparam logic [CMD_W-1:0] CMD_PIXEL  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REPLAY = 1'b1;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [WIDTH_W-1:0] width;
    } t_cfg;

    // scale clamped to 1..MAX_SCALE
    function automatic logic [CNT_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        logic [CNT_W-1:0] r;
        if (s == '0) begin
            r = CNT_W'(1);
        end else if (int'(s) > MAX_SCALE) begin
            r = CNT_W'(MAX_SCALE);
        end else begin
            r = CNT_W'(s);
        end
        return r;
    endfunction

    // width clamped to 1..MAX_WIDTH, returned minus one as the last column
    function automatic logic [COL_W-1:0] last_col(input logic [WIDTH_W-1:0] w);
        logic [COL_W-1:0] r;
        if (w == '0) begin
            r = '0;
        end else if (int'(w) > MAX_WIDTH) begin
            r = COL_W'(MAX_WIDTH - 1);
        end else begin
            r = COL_W'(w - WIDTH_W'(1));
        end
        return r;
    endfunction

    // (4 - (3*w*s) mod 4) mod 4 reduces to (w*s) mod 4
    function automatic logic [PAD_W-1:0] row_pad(input logic [COL_W-1:0] lc,
                                                 input logic [CNT_W-1:0] s);
        logic [1:0] w2;
        w2 = lc[1:0] + 2'd1;
        return PAD_W'(w2 * s[1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/bui_in_if.sv =====
`default_nettype none

interface bui_in_if;
    import bui_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/bui_out_if.sv =====
`default_nettype none

interface bui_out_if;
    import bui_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             last_of_run;
    logic             row_end;
    logic [PAD_W-1:0] pad_bytes;

    modport source (output valid, output out_pixel, output last_of_run,
                    output row_end, output pad_bytes, input ready);
    modport sink   (input valid, input out_pixel, input last_of_run,
                    input row_end, input pad_bytes, output ready);
endinterface

`default_nettype wire

// ===== sv/bui_ram.sv =====
`default_nettype none

module bui_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== sv/bui_regs.sv =====
`default_nettype none

module bui_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bui_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bui_pkg::APB_DW-1:0]  pwdata,
    output logic      [bui_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output bui_pkg::t_cfg                    o_cfg
);
    import bui_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_width;
    logic               wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= WIDTH_W'(1);
        end else if (wr) begin
            unique case (paddr[2])
                REG_SCALE: r_scale <= pwdata[SCALE_W-1:0];
                REG_WIDTH: r_width <= pwdata[WIDTH_W-1:0];
                default:   r_scale <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCALE: prdata = APB_DW'(r_scale);
            REG_WIDTH: prdata = APB_DW'(r_width);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{scale: r_scale, width: r_width};
endmodule

`default_nettype wire

// ===== sv/bmp_integer_upscaler_top.sv =====
`default_nettype none

// nearest-neighbor integer upscaler for 24-bit pixel rows. a cmd=0 transfer
// writes its pixel into the line store and produces S copies (S = scale
// factor, 0 acts as 1, above 16 saturates); once a row of row_width pixels
// is in, cmd=1 transfers replay the stored row column by column, S copies
// each, until every input row has gone out S times. a cmd=1 transfer with no
// replay owed is taken and produces nothing. the copy that closes an output
// row has row_end set and carries the bmp row padding byte count. timing:
// an input transfer is decoded, written to or read from the line store and
// loaded into the expansion register in the cycle it is accepted; that
// register then hands out one copy per cycle while the output is ready, and the
// input is ready again in the cycle that its last copy leaves (one item per
// cycle at S=1, stalls only when the output holds back). the line store is a
// single port ram, written on new pixels and read on replays. no clearing pass
// after reset. configuration is written over the apb port at 0 (scale) and
// 4 (row width) while the block is idle.
module bmp_integer_upscaler_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bui_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bui_pkg::APB_DW-1:0]  pwdata,
    output logic      [bui_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    bui_in_if.sink                           i_in,
    bui_out_if.source                        o_out
);
    import bui_pkg::*;

    t_cfg cfg;

    bui_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // row tracking state
    logic [COL_W-1:0]  r_column, n_column;
    logic [ROWS_W-1:0] r_rows_left, n_rows_left;
    logic              r_replaying, n_replaying;

    // expansion register: one accepted item and the copies it still owes
    logic              r_b_valid, n_b_valid;
    logic [CNT_W-1:0]  r_b_left, n_b_left;
    logic              r_b_replay, n_b_replay;
    logic [PIX_W-1:0]  r_b_pix, n_b_pix;
    logic              r_b_end, n_b_end;
    logic [PAD_W-1:0]  r_b_pad, n_b_pad;

    logic [CNT_W-1:0]  s_eff;
    logic [COL_W-1:0]  lcol;
    logic [COL_W-1:0]  col_raw;
    logic [COL_W-1:0]  col;
    logic              ends_row;
    logic              is_pixel;
    logic              emits;
    logic              accept;
    logic              out_xfer;
    logic              b_last;
    logic [ROWS_W-1:0] rows_dec;
    logic [PIX_W-1:0]  ram_rdata;

    assign s_eff = eff_scale(cfg.scale);
    assign lcol  = last_col(cfg.width);

    assign is_pixel = (i_in.cmd == CMD_PIXEL);
    // nothing goes out for a replay step when no replay is owed
    assign emits    = is_pixel || r_replaying;

    // a new pixel during replay abandons the replay and restarts at column 0
    assign col_raw  = (is_pixel && r_replaying) ? '0 : r_column;
    // a width lowered mid-row ends the row at the new last column
    assign ends_row = (col_raw >= lcol);
    assign col      = ends_row ? lcol : col_raw;

    assign b_last   = (r_b_left == CNT_W'(1));
    assign out_xfer = o_out.valid && o_out.ready;

    // take a new item once the expansion register is empty or drains now
    assign i_in.ready = !r_b_valid || (o_out.ready && b_last);
    assign accept     = i_in.valid && i_in.ready;

    bui_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && is_pixel),
        .i_re    (accept && !is_pixel && r_replaying),
        .i_addr  (col),
        .i_wdata (i_in.pixel),
        .o_rdata (ram_rdata)
    );

    assign rows_dec = (r_rows_left != '0) ? (r_rows_left - ROWS_W'(1)) : r_rows_left;

    // row and replay bookkeeping
    always_comb begin
        n_column    = r_column;
        n_rows_left = r_rows_left;
        n_replaying = r_replaying;
        if (accept && emits) begin
            n_column = ends_row ? '0 : COL_W'(col + COL_W'(1));
            if (is_pixel) begin
                // a finished input row owes S-1 replays
                n_rows_left = ends_row ? ROWS_W'(s_eff - CNT_W'(1)) : '0;
                n_replaying = ends_row && (s_eff > CNT_W'(1));
            end else if (ends_row) begin
                n_rows_left = rows_dec;
                n_replaying = (rows_dec != '0);
            end
        end
    end

    // expansion register load and countdown
    always_comb begin
        n_b_valid  = r_b_valid;
        n_b_left   = r_b_left;
        n_b_replay = r_b_replay;
        n_b_pix    = r_b_pix;
        n_b_end    = r_b_end;
        n_b_pad    = r_b_pad;
        if (out_xfer) begin
            n_b_left = r_b_left - CNT_W'(1);
            if (b_last) begin
                n_b_valid = 1'b0;
            end
        end
        if (accept && emits) begin
            n_b_valid  = 1'b1;
            n_b_left   = s_eff;
            n_b_replay = !is_pixel;
            n_b_pix    = i_in.pixel;
            n_b_end    = ends_row;
            n_b_pad    = row_pad(lcol, s_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_rows_left <= '0;
            r_replaying <= 1'b0;
            r_b_valid   <= 1'b0;
            r_b_left    <= '0;
        end else begin
            r_column    <= n_column;
            r_rows_left <= n_rows_left;
            r_replaying <= n_replaying;
            r_b_valid   <= n_b_valid;
            r_b_left    <= n_b_left;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_b_replay <= n_b_replay;
        r_b_pix    <= n_b_pix;
        r_b_end    <= n_b_end;
        r_b_pad    <= n_b_pad;
    end

    // replayed pixels come from the line store read data, which holds until
    // the next replay read, i.e. for the whole life of the item
    assign o_out.valid       = r_b_valid;
    assign o_out.out_pixel   = r_b_replay ? ram_rdata : r_b_pix;
    assign o_out.last_of_run = b_last;
    assign o_out.row_end     = b_last && r_b_end;
    assign o_out.pad_bytes   = (b_last && r_b_end) ? r_b_pad : '0;

    a_rows_need_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_replaying |-> (r_rows_left == '0))
        else $error("replay rows owed while not replaying");

    a_copies_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_left != '0))
        else $error("expansion register valid with no copies owed");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_last) |-> !i_in.ready)
        else $error("input taken while copies still owed");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !b_last) |=> (r_b_valid && (r_b_left == $past(r_b_left) - CNT_W'(1))))
        else $error("copy count did not step by one");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emits) |-> (col <= lcol))
        else $error("column beyond row end");

endmodule

`default_nettype wire
